>>> design/cimpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cimpm_pkg
// Shared types, sizes and the domain pattern table for the payload matcher.
// ----------------------------------------------------------------------------
package cimpm_pkg;

    localparam int SCAN_LIMIT    = 511;
    localparam int WINDOW_LEN    = 18;
    localparam int PATTERN_COUNT = 11;
    localparam int TABLE_SIZE    = 11;
    localparam int MAX_PAT       = 18;
    localparam int SEEN_W        = 10;
    localparam int INDEX_W       = 4;
    localparam int LEN_W         = 5;
    localparam int HIT_COUNT     = (PATTERN_COUNT < TABLE_SIZE) ? PATTERN_COUNT : TABLE_SIZE;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic               service_found;
        logic [INDEX_W-1:0] service_index;
    } result_t;

    // fire: staged byte moves into the scan logic this cycle
    // emit: that byte closes the packet and produces a result
    typedef struct packed {
        logic fire;
        logic emit;
    } stage_ctrl_t;

    // Right-aligned text: byte k counts back from the final character.
    typedef logic [MAX_PAT*8-1:0] pattern_t;

    localparam pattern_t PAT_TEXT [TABLE_SIZE] = '{
        pattern_t'(88'h646973636f72642e636f6d),
        pattern_t'(88'h747769747465722e636f6d),
        pattern_t'(88'h796f75747562652e636f6d),
        pattern_t'(96'h74656c656772616d2e6f7267),
        pattern_t'(96'h66616365626f6f6b2e636f6d),
        pattern_t'(104'h696e7374616772616d2e636f6d),
        pattern_t'(80'h7265646469742e636f6d),
        pattern_t'(104'h77696b6970656469612e6f7267),
        pattern_t'(88'h6e6574666c69782e636f6d),
        pattern_t'(88'h73706f746966792e636f6d),
        pattern_t'(144'h737465616d636f6d6d756e6974792e636f6d)
    };

    localparam logic [LEN_W-1:0] PAT_LEN [TABLE_SIZE] = '{
        5'd11, 5'd11, 5'd11, 5'd12, 5'd12, 5'd13, 5'd10, 5'd13, 5'd11, 5'd11, 5'd18
    };

endpackage
`default_nettype wire

>>> design/cimpm_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cimpm_in_stage
// Input register for payload bytes; issues fire/emit toward the scan logic.
// ----------------------------------------------------------------------------
module cimpm_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  cimpm_pkg::item_t          item_data,
    input  logic                      advance,
    output cimpm_pkg::stage_ctrl_t    ctrl,
    output cimpm_pkg::item_t          staged
);
    import cimpm_pkg::*;

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    logic  accept;

    // Only a closing byte waits on the output register.
    assign item_stall = stage_valid_reg && stage_item_reg.last_byte && !advance;
    assign accept     = item_valid && !item_stall;

    assign ctrl.fire = stage_valid_reg && (!stage_item_reg.last_byte || advance);
    assign ctrl.emit = ctrl.fire && stage_item_reg.last_byte;
    assign staged    = stage_item_reg;

    always_comb
    begin
        if (item_stall)
        begin
            stage_valid_next = stage_valid_reg;
        end
        else
        begin
            stage_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= item_data;
        end
    end

endmodule
`default_nettype wire

>>> design/cimpm_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cimpm_scan
// Folded byte window, parallel pattern compare, sticky hits and scan limits.
// ----------------------------------------------------------------------------
module cimpm_scan (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cimpm_pkg::stage_ctrl_t ctrl,
    input  cimpm_pkg::item_t       staged,
    output cimpm_pkg::result_t     result
);
    import cimpm_pkg::*;

    logic [7:0]           window_reg  [WINDOW_LEN-1];
    logic [7:0]           window_next [WINDOW_LEN-1];
    logic [7:0]           age         [WINDOW_LEN];
    logic [HIT_COUNT-1:0] hits_reg;
    logic [HIT_COUNT-1:0] hits_next;
    logic [HIT_COUNT-1:0] hits_now;
    logic [HIT_COUNT-1:0] match;
    logic [SEEN_W-1:0]    seen_reg;
    logic [SEEN_W-1:0]    seen_next;
    logic                 stopped_reg;
    logic                 stopped_next;
    logic [7:0]           folded;
    logic                 is_nul;
    logic                 scan_en;
    logic                 take_byte;

    always_comb
    begin
        if (staged.data_byte >= CHAR_UPPER_A && staged.data_byte <= CHAR_UPPER_Z)
        begin
            folded = staged.data_byte + CASE_OFFSET;
        end
        else
        begin
            folded = staged.data_byte;
        end
    end

    assign is_nul    = (staged.data_byte == CHAR_NUL);
    assign scan_en   = ctrl.fire && !stopped_reg && (seen_reg < SEEN_W'(SCAN_LIMIT));
    assign take_byte = scan_en && !is_nul;

    // age 0 is the incoming byte, age j the byte j positions older
    always_comb
    begin
        age[0] = folded;
        for (int j = 1; j < WINDOW_LEN; j++)
        begin
            age[j] = window_reg[j-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < HIT_COUNT; i++)
        begin
            match[i] = 1'b1;
            for (int k = 0; k < MAX_PAT; k++)
            begin
                if ((k < PAT_LEN[i]) && (age[k] != PAT_TEXT[i][8*k +: 8]))
                begin
                    match[i] = 1'b0;
                end
            end
        end
    end

    assign hits_now = take_byte ? (hits_reg | match) : hits_reg;

    // first set bit in table order
    always_comb
    begin
        result.service_found = |hits_now;
        result.service_index = '0;
        for (int i = HIT_COUNT - 1; i >= 0; i--)
        begin
            if (hits_now[i])
            begin
                result.service_index = INDEX_W'(i);
            end
        end
    end

    always_comb
    begin
        window_next  = window_reg;
        hits_next    = hits_reg;
        seen_next    = seen_reg;
        stopped_next = stopped_reg;
        if (scan_en && is_nul)
        begin
            stopped_next = 1'b1;
        end
        if (take_byte)
        begin
            window_next[0] = folded;
            for (int j = 1; j < WINDOW_LEN - 1; j++)
            begin
                window_next[j] = window_reg[j-1];
            end
            hits_next = hits_now;
            seen_next = seen_reg + SEEN_W'(1);
        end
        if (ctrl.emit)
        begin
            for (int j = 0; j < WINDOW_LEN - 1; j++)
            begin
                window_next[j] = CHAR_NUL;
            end
            hits_next    = '0;
            seen_next    = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WINDOW_LEN - 1; j++)
            begin
                window_reg[j] <= CHAR_NUL;
            end
            hits_reg    <= '0;
            seen_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            window_reg  <= window_next;
            hits_reg    <= hits_next;
            seen_reg    <= seen_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule
`default_nettype wire

>>> design/cimpm_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cimpm_out_stage
// Result register; holds a finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module cimpm_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cimpm_pkg::stage_ctrl_t ctrl,
    input  cimpm_pkg::result_t     result_in,
    output logic                   advance,
    output logic                   result_valid,
    input  logic                   result_stall,
    output cimpm_pkg::result_t     result_data
);
    import cimpm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign advance      = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result_data  = data_reg;

    always_comb
    begin
        if (advance)
        begin
            valid_next = ctrl.emit;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctrl.emit)
        begin
            data_reg <= result_in;
        end
    end

endmodule
`default_nettype wire

>>> design/case_insensitive_multi_pattern_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// case_insensitive_multi_pattern_matcher
// Scans packet payload bytes for a fixed set of domain names, ignoring case.
// ----------------------------------------------------------------------------
// Throughput: one payload byte per cycle, set by the combinational window
//   compare between the input and result registers; a closing byte waits
//   while the result register is full.
// Output: the scan result is registered and held until the consumer takes it.
// Reset: rst_n clears the window, hit bits, byte count and all valid flags.
// ----------------------------------------------------------------------------
module case_insensitive_multi_pattern_matcher (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  cimpm_pkg::item_t   item_data,
    output logic               result_valid,
    input  logic               result_stall,
    output cimpm_pkg::result_t result_data
);
    import cimpm_pkg::*;

    // Pipeline: input register -> scan logic and state -> result register.
    // A byte that does not close a packet never waits; only a closing byte
    // holds the input register while the result register is still full.
    stage_ctrl_t ctrl;
    item_t       staged;
    result_t     scan_result;
    logic        advance;

    // Hold the incoming transfer and decide when it enters the scan.
    cimpm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .advance    (advance),
        .ctrl       (ctrl),
        .staged     (staged)
    );

    // Fold case, shift the window, compare all patterns, keep sticky hits; stop at a NUL byte or the scan limit.
    // A closing byte clears everything after its result is formed.
    cimpm_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .staged (staged),
        .result (scan_result)
    );

    // Register the result; advance whenever the slot is empty or drains.
    cimpm_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .result_in    (scan_result),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

`ifndef SYNTHESIS
    // A new result only ever follows a closing byte entering the scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(ctrl.emit))
        else $error("result appeared without a closing byte");

    // No hit means index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_data.service_found) |-> (result_data.service_index == '0))
        else $error("nonzero index with no match");

    // An accepted byte either enters the scan next cycle or holds the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (ctrl.fire || item_stall))
        else $error("staged byte neither scanned nor held");
`endif

endmodule
`default_nettype wire
